// ----- hdl/dimension_order_route_assert.svh -----
// ----------------------------------------------------------------------------
// Dimension-order route assertion macros
// Shared concurrent assertion forms for the routing pipeline.
// ----------------------------------------------------------------------------
`ifndef DIMENSION_ORDER_ROUTE_ASSERT_SVH
`define DIMENSION_ORDER_ROUTE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DOR_ASSERT_SAME(label, clock, resetn, cond, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |-> (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DOR_ASSERT_NEXT(label, clock, resetn, cond, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |=> (prop)) else $error(msg);

`endif

// ----- hdl/dor_pkg.sv -----
// ----------------------------------------------------------------------------
// Dimension-order route package
// Register indexes, route control record and the radix reciprocal table.
// ----------------------------------------------------------------------------
package dor_pkg;

    // Configuration port layout.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_DIMS     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SELF_ADDRESS = 2'd2;

    // Raw register widths and radix limits.
    localparam int RADIX_W    = 5;
    localparam int NUM_DIMS_W = 3;
    localparam int DIGIT_W    = 5;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // Dimension index field, wide enough for up to eight dimensions.
    localparam int DIM_IDX_W = 3;

    // Reciprocals are scaled by two to the power RECIP_SHIFT.
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 32;

    // Routing decision carried alongside each request.
    typedef struct packed {
        logic                 done;
        logic                 bad;
        logic                 local_hit;
        logic                 dir_high;
        logic [DIM_IDX_W-1:0] dim;
    } route_t;

    // Floor of two to the 32 over the radix, for radix 2 to 16.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIX_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = 32'h8000_0000;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/dor_digit.sv -----
// ----------------------------------------------------------------------------
// Dimension-order route digit stage
// Extracts one base-radix digit of the destination and own address over two
// register stages and resolves the route if this dimension differs.
// ----------------------------------------------------------------------------
`include "dimension_order_route_assert.svh"

module dor_digit #(
    parameter int ADDR_WIDTH = 16,
    parameter int MAX_DIMS   = 4,
    parameter int DIM_INDEX  = 0
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  dor_pkg::route_t                         in_route,
    input  logic [ADDR_WIDTH-1:0]                   in_dest,
    input  logic [ADDR_WIDTH-1:0]                   in_self,
    input  logic [dor_pkg::RADIX_W-1:0]             radix,
    input  logic [dor_pkg::RECIP_W-1:0]             recip,
    input  logic [$clog2(MAX_DIMS+1)-1:0]           num_dims,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output dor_pkg::route_t                         out_route,
    output logic [ADDR_WIDTH-1:0]                   out_dest,
    output logic [ADDR_WIDTH-1:0]                   out_self
);
    import dor_pkg::*;

    localparam int PROD_W = ADDR_WIDTH + RECIP_W;
    localparam int BACK_W = ADDR_WIDTH + RADIX_W;

    // Stage A: quotient estimates.
    logic                  a_valid_reg, a_valid_next;
    route_t                a_route_reg;
    logic [ADDR_WIDTH-1:0] a_dest_reg, a_self_reg;
    logic [ADDR_WIDTH-1:0] a_qd_reg, a_qs_reg;

    // Stage B: corrected quotients and the route update.
    logic                  b_valid_reg, b_valid_next;
    route_t                b_route_reg, b_route_next;
    logic [ADDR_WIDTH-1:0] b_dest_reg, b_dest_next;
    logic [ADDR_WIDTH-1:0] b_self_reg, b_self_next;

    logic a_ready, b_ready;
    logic [PROD_W-1:0]     prod_dest, prod_self;
    logic [BACK_W-1:0]     back_dest, back_self;
    logic [ADDR_WIDTH-1:0] rem_dest, rem_self;
    logic                  fix_dest, fix_self;
    logic [DIGIT_W-1:0]    digit_dest, digit_self;
    logic                  dim_active;

    // Each stage moves when the one after it has room.
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Multiply by the scaled reciprocal; the estimate is exact or one low.
    assign prod_dest = in_dest * recip;
    assign prod_self = in_self * recip;

    assign a_valid_next = a_ready ? in_valid : a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_route_reg <= in_route;
            a_dest_reg  <= in_dest;
            a_self_reg  <= in_self;
            a_qd_reg    <= prod_dest[PROD_W-1:RECIP_SHIFT];
            a_qs_reg    <= prod_self[PROD_W-1:RECIP_SHIFT];
        end
    end

    // Remainder from the estimate, then one correction step.
    assign back_dest = a_qd_reg * radix;
    assign back_self = a_qs_reg * radix;
    assign rem_dest  = a_dest_reg - back_dest[ADDR_WIDTH-1:0];
    assign rem_self  = a_self_reg - back_self[ADDR_WIDTH-1:0];
    assign fix_dest  = BACK_W'(rem_dest) >= BACK_W'(radix);
    assign fix_self  = BACK_W'(rem_self) >= BACK_W'(radix);
    assign digit_dest = DIGIT_W'(rem_dest) - (fix_dest ? radix : '0);
    assign digit_self = DIGIT_W'(rem_self) - (fix_self ? radix : '0);
    assign dim_active = 32'(num_dims) > DIM_INDEX;

    // Resolve the route at the first dimension whose digits differ.
    always_comb
    begin
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        b_dest_next  = a_qd_reg + ADDR_WIDTH'(fix_dest);
        b_self_next  = a_qs_reg + ADDR_WIDTH'(fix_self);
        b_route_next = a_route_reg;
        if (!a_route_reg.done && dim_active && (digit_dest != digit_self))
        begin
            b_route_next.done     = 1'b1;
            b_route_next.bad      = 1'b0;
            b_route_next.dir_high = digit_dest > digit_self;
            b_route_next.dim      = DIM_IDX_W'(DIM_INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_route_reg <= b_route_next;
            b_dest_reg  <= b_dest_next;
            b_self_reg  <= b_self_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_route = b_route_reg;
    assign out_dest  = b_dest_reg;
    assign out_self  = b_self_reg;

    // A request held by the next stage keeps its route.
    `DOR_ASSERT_NEXT(a_digit_hold, clk, rst_n, b_valid_reg && !out_ready,
        b_valid_reg && $stable(b_route_reg), "digit stage dropped a held request")
    // A route already decided passes through unchanged.
    `DOR_ASSERT_NEXT(a_digit_keep, clk, rst_n, a_valid_reg && b_ready && a_route_reg.done,
        b_route_reg == $past(a_route_reg), "digit stage altered a decided route")
    // A resolved dimension route is never flagged bad.
    `DOR_ASSERT_SAME(a_digit_good, clk, rst_n, b_valid_reg && b_route_reg.done,
        !b_route_reg.bad, "decided route carries the bad flag")

endmodule

// ----- hdl/dimension_order_route.sv -----
// ----------------------------------------------------------------------------
// Dimension-order route
// Routing decision of one switch in a k-ary n-cube or mesh.
// ----------------------------------------------------------------------------
// Usage:
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// writes radix, num_dims and self_address; cfg_ready is always high. Write
// it only while no request is in flight.
// The input channel takes one destination address per request when in_valid
// is high and in_stall is low. The output channel presents out_port and
// bad_destination with out_valid; the receiver holds it with out_stall.
// The pipeline has one entry register, two registers per dimension for the
// radix reciprocal multiply and its correction, and one output register.
// Throughput is one request per cycle while out_stall is low. When out_stall
// is high, requests keep entering until every stage holds one; then in_stall
// rises. Nothing is lost or repeated. Reset empties the pipeline and loads
// radix 2, one dimension and own address 0. A self_address write takes effect
// from the next cycle; radix and num_dims also pass a clamped derived register.
// ----------------------------------------------------------------------------
`include "dimension_order_route_assert.svh"

module dimension_order_route #(
    parameter int MAX_DIMS   = 4,
    parameter int ADDR_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dor_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dor_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ADDR_WIDTH-1:0]               dest_address,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [$clog2(2*MAX_DIMS+1)-1:0]     out_port,
    output logic                                bad_destination
);
    import dor_pkg::*;

    localparam int DIMS_W = $clog2(MAX_DIMS + 1);
    localparam int PORT_W = $clog2(2 * MAX_DIMS + 1);
    localparam int FIELD_W = (ADDR_WIDTH < CFG_DATA_W) ? ADDR_WIDTH : CFG_DATA_W;

    // Raw configuration registers.
    logic [RADIX_W-1:0]    radix_reg;
    logic [NUM_DIMS_W-1:0] num_dims_reg;
    logic [ADDR_WIDTH-1:0] self_address_reg;

    // Registers derived from the configuration.
    logic [RADIX_W-1:0]    eff_radix_reg, eff_radix_next;
    logic [RECIP_W-1:0]    recip_reg;
    logic [DIMS_W-1:0]     eff_dims_reg, eff_dims_next;

    // Entry stage.
    logic                  s0_valid_reg, s0_valid_next;
    route_t                s0_route_reg, s0_route_next;
    logic [ADDR_WIDTH-1:0] s0_dest_reg, s0_self_reg;
    logic [ADDR_WIDTH-1:0] dest_in;
    logic                  s0_ready;

    // Digit stage chain; index j is the input of digit stage j, index j+1 its output.
    logic                  chain_valid [MAX_DIMS+1];
    logic                  chain_ready [MAX_DIMS+1];
    route_t                chain_route [MAX_DIMS+1];
    logic [ADDR_WIDTH-1:0] chain_dest  [MAX_DIMS+1];
    logic [ADDR_WIDTH-1:0] chain_self  [MAX_DIMS+1];

    // Output stage.
    logic                  out_valid_reg, out_valid_next;
    logic [PORT_W-1:0]     out_port_reg, out_port_next;
    logic                  out_bad_reg;
    logic                  out_ready;
    route_t                last_route;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_MIN;
            num_dims_reg     <= NUM_DIMS_W'(1);
            self_address_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RADIX:        radix_reg        <= cfg_data[RADIX_W-1:0];
                CFG_NUM_DIMS:     num_dims_reg     <= cfg_data[NUM_DIMS_W-1:0];
                CFG_SELF_ADDRESS: self_address_reg <= ADDR_WIDTH'(cfg_data[FIELD_W-1:0]);
                default:          ;
            endcase
        end
    end

    // Clamp the radix and dimension count into their supported ranges.
    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            eff_radix_next = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            eff_radix_next = RADIX_MAX;
        end
        else
        begin
            eff_radix_next = radix_reg;
        end

        if (num_dims_reg == '0)
        begin
            eff_dims_next = DIMS_W'(1);
        end
        else if (32'(num_dims_reg) > MAX_DIMS)
        begin
            eff_dims_next = DIMS_W'(MAX_DIMS);
        end
        else
        begin
            eff_dims_next = DIMS_W'(num_dims_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_radix_reg <= RADIX_MIN;
            recip_reg     <= recip_of(RADIX_MIN);
            eff_dims_reg  <= DIMS_W'(1);
        end
        else
        begin
            eff_radix_reg <= eff_radix_next;
            recip_reg     <= recip_of(eff_radix_next);
            eff_dims_reg  <= eff_dims_next;
        end
    end

    // Entry stage: catch the request and check for the local port.
    assign dest_in  = ADDR_WIDTH'(dest_address[FIELD_W-1:0]);
    assign s0_ready = !s0_valid_reg || chain_ready[0];
    assign in_stall = !s0_ready;

    always_comb
    begin
        s0_valid_next           = s0_ready ? in_valid : s0_valid_reg;
        s0_route_next.local_hit = dest_in == self_address_reg;
        s0_route_next.done      = s0_route_next.local_hit;
        s0_route_next.bad       = !s0_route_next.local_hit;
        s0_route_next.dir_high  = 1'b0;
        s0_route_next.dim       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s0_ready)
        begin
            s0_route_reg <= s0_route_next;
            s0_dest_reg  <= dest_in;
            s0_self_reg  <= self_address_reg;
        end
    end

    assign chain_valid[0] = s0_valid_reg;
    assign chain_route[0] = s0_route_reg;
    assign chain_dest[0]  = s0_dest_reg;
    assign chain_self[0]  = s0_self_reg;

    // One digit stage pair per dimension, lowest dimension first.
    for (genvar j = 0; j < MAX_DIMS; j++)
    begin : g_digit
        dor_digit #(
            .ADDR_WIDTH (ADDR_WIDTH),
            .MAX_DIMS   (MAX_DIMS),
            .DIM_INDEX  (j)
        ) u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[j]),
            .in_ready  (chain_ready[j]),
            .in_route  (chain_route[j]),
            .in_dest   (chain_dest[j]),
            .in_self   (chain_self[j]),
            .radix     (eff_radix_reg),
            .recip     (recip_reg),
            .num_dims  (eff_dims_reg),
            .out_valid (chain_valid[j+1]),
            .out_ready (chain_ready[j+1]),
            .out_route (chain_route[j+1]),
            .out_dest  (chain_dest[j+1]),
            .out_self  (chain_self[j+1])
        );
    end

    // Output stage: turn the route record into a port number.
    assign out_ready             = !out_valid_reg || !out_stall;
    assign chain_ready[MAX_DIMS] = out_ready;
    assign last_route            = chain_route[MAX_DIMS];

    always_comb
    begin
        out_valid_next = out_ready ? chain_valid[MAX_DIMS] : out_valid_reg;
        if (last_route.local_hit)
        begin
            out_port_next = PORT_W'({eff_dims_reg, 1'b0});
        end
        else if (last_route.dir_high)
        begin
            out_port_next = PORT_W'(last_route.dim) + PORT_W'(eff_dims_reg);
        end
        else
        begin
            out_port_next = PORT_W'(last_route.dim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[MAX_DIMS] && out_ready)
        begin
            out_port_reg <= out_port_next;
            out_bad_reg  <= last_route.bad;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_port        = out_port_reg;
    assign bad_destination = out_bad_reg;

    // A bad destination always reports port zero.
    `DOR_ASSERT_SAME(a_route_bad_port, clk, rst_n, out_valid_reg && out_bad_reg,
        out_port_reg == '0, "bad destination with a nonzero port")
    // The port never exceeds the local host port.
    `DOR_ASSERT_SAME(a_route_port_range, clk, rst_n, out_valid_reg,
        32'(out_port_reg) <= 2 * 32'(eff_dims_reg), "port beyond the local host port")
    // A request blocked at the entry stage stays there.
    `DOR_ASSERT_NEXT(a_route_entry_hold, clk, rst_n, s0_valid_reg && !chain_ready[0],
        s0_valid_reg && $stable(s0_dest_reg), "entry stage lost a blocked request")

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Dimension-order route testbench
// Sends destination requests through dimension_order_route under many radix,
// dimension and own-address settings, with random idle gaps on the request
// side and random stalls on the decision side. A scoreboard predicts each
// routing decision and checks every decision that leaves the block in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dor_pkg::*;

    localparam int DIMS_LIMIT    = 4;
    localparam int ADDR_W        = 16;
    localparam int ROUTE_LATENCY = 2 * DIMS_LIMIT + 2;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 163;

    // Index that selects no register; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [3:0] port;
        logic       bad;
    } route_decision_t;

    typedef enum int {
        DEST_LOCAL,
        DEST_LOWER,
        DEST_HIGHER,
        DEST_BEYOND,
        DEST_ANY
    } dest_kind_e;

    // Scoreboard: mirrors the registers and queues the expected decisions.
    class route_scoreboard;
        logic [RADIX_W-1:0]    radix_reg;
        logic [NUM_DIMS_W-1:0] dims_reg;
        logic [ADDR_W-1:0]     self_reg;
        route_decision_t       pending_q[$];
        int                    mismatches;
        int                    routed;

        function new();
            radix_reg  = 5'd2;
            dims_reg   = 3'd1;
            self_reg   = '0;
            mismatches = 0;
            routed     = 0;
        endfunction

        // Radix as the block uses it, clamped to the legal range.
        function int digit_base(logic [RADIX_W-1:0] raw);
            if (raw < RADIX_MIN) return RADIX_MIN;
            if (raw > RADIX_MAX) return RADIX_MAX;
            return raw;
        endfunction

        // Dimension count as the block uses it, clamped to one and the maximum.
        function int dim_count(logic [NUM_DIMS_W-1:0] raw);
            if (raw == 0) return 1;
            if (raw > DIMS_LIMIT) return DIMS_LIMIT;
            return raw;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx,
                                   logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RADIX:        radix_reg = data[RADIX_W-1:0];
                CFG_NUM_DIMS:     dims_reg  = data[NUM_DIMS_W-1:0];
                CFG_SELF_ADDRESS: self_reg  = data[ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        // Walk the digits from the lowest dimension up to the first difference.
        function route_decision_t route_of(logic [ADDR_W-1:0] dest);
            int k, n, d, s, j;
            route_decision_t r;
            k = digit_base(radix_reg);
            n = dim_count(dims_reg);
            d = dest;
            s = self_reg;
            r.port = '0;
            r.bad  = 1'b1;
            if (d == s) begin
                r.port = 2 * n;
                r.bad  = 1'b0;
            end
            else begin
                for (j = 0; j < n && r.bad; j++) begin
                    if (d % k != s % k) begin
                        r.port = (d % k < s % k) ? j : j + n;
                        r.bad  = 1'b0;
                    end
                    d = d / k;
                    s = s / k;
                end
            end
            return r;
        endfunction

        function void note_request(logic [ADDR_W-1:0] dest);
            pending_q.push_back(route_of(dest));
        endfunction

        task report(string msg);
            $display("Mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [3:0] port, logic bad);
            route_decision_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("decision port %0d bad %0d with no request waiting",
                                 port, bad));
                return;
            end
            want = pending_q.pop_front();
            routed++;
            if (port !== want.port)
                report($sformatf("out_port %0d, expected %0d", port, want.port));
            if (bad !== want.bad)
                report($sformatf("bad_destination %0b, expected %0b", bad, want.bad));
        endtask
    endclass

    logic                   clk             = 1'b0;
    logic                   rst_n           = 1'b0;
    logic                   cfg_valid       = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index       = '0;
    logic [CFG_DATA_W-1:0]  cfg_data        = '0;
    logic                   in_valid        = 1'b0;
    logic                   in_stall;
    logic [ADDR_W-1:0]      dest_address    = '0;
    logic                   out_valid;
    logic                   out_stall       = 1'b0;
    logic [3:0]             out_port;
    logic                   bad_destination;

    route_scoreboard routes = new();

    // Stimulus view of the current settings.
    logic [RADIX_W-1:0]    cur_radix = 5'd2;
    logic [NUM_DIMS_W-1:0] cur_dims  = 3'd1;
    logic [ADDR_W-1:0]     cur_self  = '0;
    bit                    no_gaps   = 1'b0;
    int                    phases    = 1;
    int                    cycles    = 0;
    int                    requests_taken = 0;

    dimension_order_route #(
        .MAX_DIMS   (DIMS_LIMIT),
        .ADDR_WIDTH (ADDR_W)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .dest_address    (dest_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_port        (out_port),
        .bad_destination (bad_destination)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Monitor: check decisions, record requests and register writes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                routes.check_result(out_port, bad_destination);
            if (in_valid && !in_stall)
            begin
                routes.note_request(dest_address);
                requests_taken <= requests_taken + 1;
            end
            if (cfg_valid && cfg_ready)
                routes.set_register(cfg_index, cfg_data);
        end
    end

    // Most gaps are short, a few are long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: random stalls, free stretches, and occasional long hold-offs.
    int hold_left    = 0;
    int stall_left   = 0;
    int free_left    = 0;
    int next_hold_at = 370;
    int holds_done   = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (requests_taken >= next_hold_at)
            begin
                hold_left    = 100;
                next_hold_at = next_hold_at + 900;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (free_left > 0)
                    free_left--;
                else
                begin
                    free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(0, 6);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Number of addresses inside the configured network.
    function automatic int net_span(logic [RADIX_W-1:0] r, logic [NUM_DIMS_W-1:0] n);
        int k, span, j;
        k = routes.digit_base(r);
        span = 1;
        for (j = 0; j < routes.dim_count(n); j++)
            span *= k;
        return span;
    endfunction

    function automatic dest_kind_e pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return DEST_LOCAL;
        if (r < 45) return DEST_LOWER;
        if (r < 75) return DEST_HIGHER;
        if (r < 85) return DEST_BEYOND;
        return DEST_ANY;
    endfunction

    // Build a destination of the requested kind around the current own address.
    function automatic logic [ADDR_W-1:0] pick_destination(dest_kind_e kind);
        int k, n, span, low, upper, j, t, pos, tries, value, weight, dig, maxm, m;
        int sd[DIMS_LIMIT];
        k     = routes.digit_base(cur_radix);
        n     = routes.dim_count(cur_dims);
        span  = net_span(cur_radix, cur_dims);
        low   = cur_self % span;
        upper = cur_self / span;
        t     = low;
        for (j = 0; j < n; j++)
        begin
            sd[j] = t % k;
            t     = t / k;
        end
        case (kind)
            DEST_LOCAL:
                return cur_self;
            DEST_LOWER, DEST_HIGHER:
            begin
                pos   = $urandom_range(0, n - 1);
                tries = 0;
                while (tries < n && ((kind == DEST_LOWER) ? (sd[pos] == 0)
                                                          : (sd[pos] == k - 1)))
                begin
                    pos = (pos + 1) % n;
                    tries++;
                end
                if (tries == n)
                    return $urandom_range(0, 65535);
                value  = 0;
                weight = 1;
                for (j = 0; j < n; j++)
                begin
                    if (j < pos)
                        dig = sd[j];
                    else if (j == pos)
                        dig = (kind == DEST_LOWER) ? $urandom_range(0, sd[j] - 1)
                                                   : $urandom_range(sd[j] + 1, k - 1);
                    else
                        dig = $urandom_range(0, k - 1);
                    value  += dig * weight;
                    weight *= k;
                end
                return value;
            end
            DEST_BEYOND:
            begin
                // Same low digits as the own address, different above them.
                if (span > 65535 - low)
                    return $urandom_range(0, 65535);
                maxm = (65535 - low) / span;
                m    = $urandom_range(1, maxm);
                if (m == upper)
                    m = (m > 1) ? m - 1 : m + 1;
                if (m > maxm)
                    return $urandom_range(0, 65535);
                return low + m * span;
            end
            default:
                return $urandom_range(0, 65535);
        endcase
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Wait until the pipeline has drained, then write all three registers.
    task automatic configure(input logic [RADIX_W-1:0] r, input logic [NUM_DIMS_W-1:0] n,
                             input logic [ADDR_W-1:0] s, input bit touch_spare);
        logic [CFG_DATA_W-1:0] noise;
        in_valid <= 1'b0;
        // The wait below lets the monitor record the last request.
        @(posedge clk);
        while (routes.pending_q.size() != 0)
            @(posedge clk);
        noise = $urandom;
        write_register(CFG_RADIX, {noise[CFG_DATA_W-1:RADIX_W], r});
        noise = $urandom;
        write_register(CFG_NUM_DIMS, {noise[CFG_DATA_W-1:NUM_DIMS_W], n});
        write_register(CFG_SELF_ADDRESS, s);
        if (touch_spare)
            write_register(CFG_SPARE, $urandom);
        cfg_valid <= 1'b0;
        cur_radix = r;
        cur_dims  = n;
        cur_self  = s;
        phases++;
    endtask

    task automatic send_request(input logic [ADDR_W-1:0] d);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        dest_address <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Main sequence.
    initial
    begin
        int p, i;
        logic [RADIX_W-1:0]    r;
        logic [NUM_DIMS_W-1:0] n;
        logic [ADDR_W-1:0]     s;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: radix 2, one dimension, own address 0.
        send_request(16'h0000);
        send_request(16'h0001);
        send_request(16'h0002);
        send_request(16'hFFFF);
        send_request(16'hFFFE);

        // Radix 3, two dimensions, own digits 1 and 1; spare index written too.
        configure(5'd3, 3'd2, 16'd4, 1'b1);
        send_request(16'd4);
        send_request(16'd3);
        send_request(16'd5);
        send_request(16'd1);
        send_request(16'd7);
        send_request(16'd13);

        // Radix and dimensions below range; own address outside the network.
        configure(5'd0, 3'd0, 16'hFFFF, 1'b0);
        send_request(16'hFFFF);
        send_request(16'h0000);
        send_request(16'h0001);

        // Radix and dimensions above range.
        configure(5'd31, 3'd7, 16'h8421, 1'b0);
        send_request(16'h8421);
        send_request(16'h8420);
        send_request(16'h9421);
        send_request(16'h0421);
        send_request(16'h8431);

        // Radix one, four binary dimensions: equal low digits, differing above.
        configure(5'd1, 3'd4, 16'h0000, 1'b0);
        send_request(16'h0010);
        send_request(16'h0008);

        // Random phases, the first two at the largest and smallest networks.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                r = RADIX_MAX;
                n = DIMS_LIMIT;
            end
            else if (p == 1)
            begin
                r = RADIX_MIN;
                n = 3'd1;
            end
            else
            begin
                r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(2, 16);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(1, DIMS_LIMIT);
            end
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, net_span(r, n) - 1);
            configure(r, n, s, 1'b0);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(pick_destination(pick_kind()));
            no_gaps = 1'b0;
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then give any stray decision time to show up.
        while (routes.pending_q.size() != 0)
            @(posedge clk);
        repeat (ROUTE_LATENCY + 4) @(posedge clk);

        $display("Checked %0d routing decisions over %0d network settings,",
                 routes.routed, phases);
        $display("including clamped radix and dimension values and %0d long hold-offs.",
                 holds_done);
        if (routes.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
